// ===== design/bsle_pkg.sv =====
// Package for the bounded sequence list engine.
// Holds sizes, request codes and status codes shared by the core and its checker.
// Depends on nothing.
package bsle_pkg;

    // Store size and derived widths.
    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed widths of the transaction fields.
    localparam int MODE_W = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int FIDX_W = 6;
    localparam int ECNT_W = 7;

    // Width that holds both a position and a count for comparisons.
    localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

    // Request codes.
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_BACK   = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_INSERT     = 3'd4,
        MODE_ERASE      = 3'd5,
        MODE_FIND       = 3'd6,
        MODE_MODIFY     = 3'd7
    } t_mode;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

endpackage

// ===== design/bsle_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered and appears in the cycle after the read request.
// Depends on nothing.
module bsle_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== design/bounded_sequence_list_engine_core.sv =====
// Top level of the bounded sequence list engine: request decoder, sequencer and list store.
// Depends on bsle_pkg and bsle_ram.
//
// A request is taken when start is high and busy is low, and its single result is
// shown for one cycle with o_valid high; the receiver must take it then. Push back,
// pop back, modify, and every request that ends in an error answer on the next
// cycle and leave busy low, so requests of that kind can follow back to back.
// Insert and push front move the entries from the insert position up to the end one
// place up, one entry per cycle through the store's single read and write ports.
// Erase and pop front move the later entries down the same way. Find reads the
// store from index 0 one entry per cycle and stops at the first hit or once every
// entry is read. The walk over the store (at most 64 entries) sets the worst case.
module bounded_sequence_list_engine_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [bsle_pkg::MODE_W-1:0]     i_mode,
    input  logic [bsle_pkg::POS_W-1:0]      i_position,
    input  logic signed [bsle_pkg::DATA_W-1:0] i_value,
    output logic                            o_valid,
    output logic [bsle_pkg::STAT_W-1:0]     o_status,
    output logic                            o_found,
    output logic [bsle_pkg::FIDX_W-1:0]     o_found_index,
    output logic [bsle_pkg::ECNT_W-1:0]     o_element_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_UP_LAST,
        S_INS_WR,
        S_DN,
        S_DN_LAST,
        S_FIND
    } t_state;

    t_state                         r_state;
    logic [bsle_pkg::CNT_W-1:0]     r_count;
    logic [bsle_pkg::CNT_W-1:0]     r_pos;
    logic [bsle_pkg::CNT_W-1:0]     r_addr;
    logic [bsle_pkg::IDX_W-1:0]     r_prev;
    logic                           r_pend;
    logic [bsle_pkg::DATA_W-1:0]    r_val;

    // Store port signals.
    logic                           w_we;
    logic [bsle_pkg::IDX_W-1:0]     w_waddr;
    logic [bsle_pkg::DATA_W-1:0]    w_wdata;
    logic                           w_re;
    logic [bsle_pkg::IDX_W-1:0]     w_raddr;
    logic [bsle_pkg::DATA_W-1:0]    w_rdata;

    // Decode helpers.
    logic                           w_accept;
    bsle_pkg::t_mode                w_mode;
    logic [bsle_pkg::CMP_W-1:0]     w_epos;
    logic [bsle_pkg::CMP_W-1:0]     w_cnt;
    logic                           w_full;
    logic                           w_empty;
    logic                           w_issue;
    logic                           w_hit;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_mode   = bsle_pkg::t_mode'(i_mode);
    assign w_cnt    = bsle_pkg::CMP_W'(r_count);
    assign w_full   = (r_count == bsle_pkg::CNT_W'(bsle_pkg::DEPTH));
    assign w_empty  = (r_count == '0);

    // Push front and pop front work as insert and erase at position zero.
    always_comb begin
        if (w_mode == bsle_pkg::MODE_PUSH_FRONT || w_mode == bsle_pkg::MODE_POP_FRONT) begin
            w_epos = '0;
        end else begin
            w_epos = bsle_pkg::CMP_W'(i_position);
        end
    end

    // A find issues reads until the read pointer reaches the count.
    assign w_issue = (r_addr != r_count);
    assign w_hit   = r_pend && (w_rdata == r_val);

    // Store access control. Shifts read one entry ahead of the write, so the read
    // and write addresses of a cycle never meet; busy keeps new requests out.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = w_rdata;
        w_re    = 1'b0;
        w_raddr = r_addr[bsle_pkg::IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                w_wdata = i_value;
                if (w_accept) begin
                    case (w_mode)
                        bsle_pkg::MODE_PUSH_BACK: begin
                            w_we    = !w_full;
                            w_waddr = r_count[bsle_pkg::IDX_W-1:0];
                        end
                        bsle_pkg::MODE_PUSH_FRONT, bsle_pkg::MODE_INSERT: begin
                            w_we    = (w_epos == w_cnt) && !w_full;
                            w_waddr = r_count[bsle_pkg::IDX_W-1:0];
                        end
                        bsle_pkg::MODE_MODIFY: begin
                            w_we    = (w_epos < w_cnt);
                            w_waddr = bsle_pkg::IDX_W'(i_position);
                        end
                        default: begin
                            w_we = 1'b0;
                        end
                    endcase
                end
            end
            S_UP: begin
                w_re    = 1'b1;
                w_we    = r_pend;
                w_waddr = r_prev + 1'b1;
            end
            S_UP_LAST: begin
                w_we    = 1'b1;
                w_waddr = r_prev + 1'b1;
            end
            S_INS_WR: begin
                w_we    = 1'b1;
                w_waddr = r_pos[bsle_pkg::IDX_W-1:0];
                w_wdata = r_val;
            end
            S_DN: begin
                w_re    = 1'b1;
                w_we    = r_pend;
                w_waddr = r_prev - 1'b1;
            end
            S_DN_LAST: begin
                w_we    = 1'b1;
                w_waddr = r_prev - 1'b1;
            end
            S_FIND: begin
                w_re = w_issue;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Sequencer and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_val           <= i_value;
                        r_pend          <= 1'b0;
                        o_status        <= bsle_pkg::ST_OK;
                        o_found         <= 1'b0;
                        o_found_index   <= '0;
                        o_element_count <= bsle_pkg::ECNT_W'(r_count);
                        case (w_mode)
                            bsle_pkg::MODE_PUSH_BACK: begin
                                o_valid <= 1'b1;
                                if (w_full) begin
                                    o_status <= bsle_pkg::ST_FULL;
                                end else begin
                                    r_count         <= r_count + 1'b1;
                                    o_element_count <= bsle_pkg::ECNT_W'(r_count + 1'b1);
                                end
                            end
                            bsle_pkg::MODE_POP_BACK: begin
                                o_valid <= 1'b1;
                                if (w_empty) begin
                                    o_status <= bsle_pkg::ST_EMPTY;
                                end else begin
                                    r_count         <= r_count - 1'b1;
                                    o_element_count <= bsle_pkg::ECNT_W'(r_count - 1'b1);
                                end
                            end
                            bsle_pkg::MODE_MODIFY: begin
                                o_valid <= 1'b1;
                                if (w_epos >= w_cnt) begin
                                    o_status <= bsle_pkg::ST_RANGE;
                                end
                            end
                            bsle_pkg::MODE_PUSH_FRONT, bsle_pkg::MODE_INSERT: begin
                                if (w_epos > w_cnt) begin
                                    o_valid  <= 1'b1;
                                    o_status <= bsle_pkg::ST_RANGE;
                                end else if (w_full) begin
                                    o_valid  <= 1'b1;
                                    o_status <= bsle_pkg::ST_FULL;
                                end else if (w_epos == w_cnt) begin
                                    o_valid         <= 1'b1;
                                    r_count         <= r_count + 1'b1;
                                    o_element_count <= bsle_pkg::ECNT_W'(r_count + 1'b1);
                                end else begin
                                    r_state <= S_UP;
                                    r_addr  <= r_count - 1'b1;
                                    r_pos   <= bsle_pkg::CNT_W'(w_epos);
                                end
                            end
                            bsle_pkg::MODE_POP_FRONT, bsle_pkg::MODE_ERASE: begin
                                if (w_epos >= w_cnt) begin
                                    o_valid <= 1'b1;
                                    if (w_mode == bsle_pkg::MODE_POP_FRONT) begin
                                        o_status <= bsle_pkg::ST_EMPTY;
                                    end else begin
                                        o_status <= bsle_pkg::ST_RANGE;
                                    end
                                end else if (w_epos == w_cnt - 1'b1) begin
                                    o_valid         <= 1'b1;
                                    r_count         <= r_count - 1'b1;
                                    o_element_count <= bsle_pkg::ECNT_W'(r_count - 1'b1);
                                end else begin
                                    r_state <= S_DN;
                                    r_addr  <= bsle_pkg::CNT_W'(w_epos) + 1'b1;
                                    r_pos   <= bsle_pkg::CNT_W'(w_epos);
                                end
                            end
                            bsle_pkg::MODE_FIND: begin
                                if (w_empty) begin
                                    o_valid <= 1'b1;
                                end else begin
                                    r_state <= S_FIND;
                                    r_addr  <= '0;
                                end
                            end
                            default: begin
                                o_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                // Walk down from the last entry to the insert position.
                S_UP: begin
                    r_pend <= 1'b1;
                    r_prev <= r_addr[bsle_pkg::IDX_W-1:0];
                    if (r_addr == r_pos) begin
                        r_state <= S_UP_LAST;
                    end else begin
                        r_addr <= r_addr - 1'b1;
                    end
                end
                S_UP_LAST: begin
                    r_state <= S_INS_WR;
                end
                S_INS_WR: begin
                    r_state         <= S_IDLE;
                    r_count         <= r_count + 1'b1;
                    o_valid         <= 1'b1;
                    o_element_count <= bsle_pkg::ECNT_W'(r_count + 1'b1);
                end
                // Walk up from the entry after the erase position to the last entry.
                S_DN: begin
                    r_pend <= 1'b1;
                    r_prev <= r_addr[bsle_pkg::IDX_W-1:0];
                    if (r_addr == r_count - 1'b1) begin
                        r_state <= S_DN_LAST;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_DN_LAST: begin
                    r_state         <= S_IDLE;
                    r_count         <= r_count - 1'b1;
                    o_valid         <= 1'b1;
                    o_element_count <= bsle_pkg::ECNT_W'(r_count - 1'b1);
                end
                // Compare each returned entry against the search value.
                S_FIND: begin
                    r_pend <= w_issue;
                    r_prev <= r_addr[bsle_pkg::IDX_W-1:0];
                    if (w_issue) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (w_hit) begin
                        r_state       <= S_IDLE;
                        o_valid       <= 1'b1;
                        o_found       <= 1'b1;
                        o_found_index <= bsle_pkg::FIDX_W'(r_prev);
                    end else if (!w_issue) begin
                        r_state <= S_IDLE;
                        o_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // List store.
    bsle_ram #(
        .DEPTH (bsle_pkg::DEPTH),
        .WIDTH (bsle_pkg::DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

endmodule

// ===== design/bsle_checker.sv =====
// Port-level checks for the bounded sequence list engine, bound to the top level.
// Depends on bsle_pkg and bounded_sequence_list_engine_core.
module bsle_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            o_valid,
    input logic [bsle_pkg::STAT_W-1:0]     o_status,
    input logic                            o_found,
    input logic [bsle_pkg::FIDX_W-1:0]     o_found_index,
    input logic [bsle_pkg::ECNT_W-1:0]     o_element_count
);

    // The count never goes past the store size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_element_count <= bsle_pkg::ECNT_W'(bsle_pkg::DEPTH)))
        else $error("element count above store size");

    // A hit is reported only with an ok status.
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_status == bsle_pkg::ST_OK))
        else $error("found with error status");

    // Without a hit the index reads zero.
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_found_index == '0))
        else $error("nonzero index without a hit");

    // Busy only rises after a transaction is taken.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a transaction");

    // A multi-cycle transaction ends with its result.
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_valid)
        else $error("busy fell without a result");

endmodule

bind bounded_sequence_list_engine_core bsle_checker u_bsle_checker (.*);
